@@ sv/sdtq_pkg.sv @@
package sdtq_pkg;

    // command codes carried in the input tuser
    localparam logic [1:0] CMD_REGISTER = 2'd0;
    localparam logic [1:0] CMD_ADJUST   = 2'd1;
    localparam logic [1:0] CMD_QUERY    = 2'd2;
    localparam logic [1:0] CMD_TICK     = 2'd3;

    // result kinds carried in the output tuser
    localparam logic [1:0] KIND_REG_ACK = 2'd0;
    localparam logic [1:0] KIND_ADJ_ACK = 2'd1;
    localparam logic [1:0] KIND_REMAIN  = 2'd2;
    localparam logic [1:0] KIND_FIRED   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_BAD_DELAY = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // operations broadcast to every cell
    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_POP    = 2'd3;

    // most timers fired by one tick
    localparam int MAX_FIRE = 16;

    typedef struct packed {
        logic        valid;
        logic [7:0]  id;
        logic [31:0] start;
        logic [31:0] deadline;
    } t_entry;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  key;
        logic [31:0] start;
        logic [31:0] deadline;
    } t_cell_ctl;

endpackage

@@ sv/sdtq_cell.sv @@
module sdtq_cell
    import sdtq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_left,
    input  logic      i_left_stay,
    input  t_entry    i_right,
    input  logic      i_seen_in,
    output t_entry    o_entry,
    output logic      o_stay,
    output logic      o_seen,
    output logic      o_first
);

    logic        r_valid;
    logic [7:0]  r_id;
    logic [31:0] r_start;
    logic [31:0] r_deadline;
    t_entry      n_entry;
    logic        w_match;

    assign o_entry = '{valid: r_valid, id: r_id, start: r_start, deadline: r_deadline};

    // keep place on insert when this deadline is not later than the new one
    assign o_stay  = r_valid && ($signed(r_deadline) <= $signed(i_ctl.deadline));

    // earliest-match chain for id lookup
    assign w_match = r_valid && (r_id == i_ctl.key);
    assign o_seen  = i_seen_in | w_match;
    assign o_first = w_match & ~i_seen_in;

    // select next contents: hold, take new timer, shift from left or right
    always_comb begin
        n_entry = o_entry;
        case (i_ctl.op)
            OP_INSERT: begin
                if (!o_stay) begin
                    if (i_left_stay) begin
                        n_entry = '{valid: 1'b1, id: i_ctl.key, start: i_ctl.start,
                                    deadline: i_ctl.deadline};
                    end else begin
                        n_entry = i_left;
                    end
                end
            end
            OP_REMOVE: begin
                if (o_seen) begin
                    n_entry = i_right;
                end
            end
            OP_POP: begin
                n_entry = i_right;
            end
            default: begin
                n_entry = o_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id       <= n_entry.id;
        r_start    <= n_entry.start;
        r_deadline <= n_entry.deadline;
    end

endmodule

@@ sv/sorted_deadline_timer_queue.sv @@
// Sequence: a command word is captured on acceptance and runs in S_EXEC; register, query
// and unmatched or canceling adjust words load their result word there, while a re-inserting
// adjust removes the timer there and loads its result word from S_REINS. A tick goes from
// S_EXEC to S_FIRE and gives one fired word per cycle while the output is free (at most 16
// per tick). A new word is taken only back in S_IDLE; a repeated tick time goes straight there.
// Reset (synchronous, active low) empties all cells and sets the last tick time to zero.
module sorted_deadline_timer_queue
    import sdtq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,  // id[7:0], delay[39:8], now_ms[71:40]
    input  logic [1:0]  i_s_axis_tuser,  // command[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,  // fired_id[7:0], time_value[38:8], status[40:39], zero
    output logic [1:0]  o_m_axis_tuser,  // kind[1:0]
    output logic        o_m_axis_tlast
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_REINS = 2'd2;
    localparam logic [1:0] S_FIRE  = 2'd3;
    localparam int CNT_W = $clog2(MAX_FIRE + 1);

    logic [1:0]       r_state, n_state;
    logic [1:0]       r_cmd;
    logic [7:0]       r_id;
    logic [31:0]      r_dly;
    logic [31:0]      r_now;
    logic [31:0]      r_last_tick, n_last_tick;
    logic [31:0]      r_adj_start, r_adj_dl;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic             r_out_valid;
    logic [1:0]       r_out_kind, n_out_kind;
    logic [7:0]       r_out_id, n_out_id;
    logic [30:0]      r_out_tv, n_out_tv;
    logic [1:0]       r_out_st, n_out_st;
    logic             r_out_last, n_out_last;
    logic             w_load;

    t_cell_ctl        w_ctl;
    t_entry           w_entry [DEPTH];
    logic [DEPTH:0]   w_stay;
    logic [DEPTH:0]   w_seen;
    logic [DEPTH-1:0] w_first;
    logic [DEPTH-1:0] w_valid;
    logic [DEPTH:0]   w_due;
    logic [31:0]      w_found_start, w_found_dl;
    logic             w_out_free, w_accept, w_dly_ok;
    logic [31:0]      w_remain, w_elapsed;
    logic             w_next_due;

    assign w_stay[0] = 1'b1;
    assign w_seen[0] = 1'b0;
    assign w_due[DEPTH] = 1'b0;

    // row of timer cells, kept sorted by deadline
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry w_left, w_right;
        if (g == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = w_entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_entry[g+1];
        end
        sdtq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_left      (w_left),
            .i_left_stay (w_stay[g]),
            .i_right     (w_right),
            .i_seen_in   (w_seen[g]),
            .o_entry     (w_entry[g]),
            .o_stay      (w_stay[g+1]),
            .o_seen      (w_seen[g+1]),
            .o_first     (w_first[g])
        );
        assign w_valid[g] = w_entry[g].valid;
        assign w_due[g]   = w_entry[g].valid &&
                            ($signed(w_entry[g].deadline) <= $signed(r_now));
    end

    // pick the fields of the earliest matching timer
    always_comb begin
        w_found_start = '0;
        w_found_dl    = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_first[i]) begin
                w_found_start = w_found_start | w_entry[i].start;
                w_found_dl    = w_found_dl | w_entry[i].deadline;
            end
        end
    end

    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_accept   = i_s_axis_tvalid && (r_state == S_IDLE);
    assign w_dly_ok   = !r_dly[31] && (r_dly != 32'd0);
    assign w_remain   = w_found_dl - r_now;
    assign w_elapsed  = r_now - w_entry[0].start;
    assign w_next_due = w_due[1] && (r_cnt < CNT_W'(MAX_FIRE - 1));

    // sequence each command and drive the cell row
    always_comb begin
        n_state     = r_state;
        n_last_tick = r_last_tick;
        n_cnt       = r_cnt;
        w_ctl       = '{op: OP_NONE, key: r_id, start: r_now, deadline: r_now + r_dly};
        w_load      = 1'b0;
        n_out_kind  = r_out_kind;
        n_out_id    = r_id;
        n_out_tv    = '0;
        n_out_st    = ST_DONE;
        n_out_last  = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_cmd)
                    CMD_REGISTER: begin
                        if (w_out_free) begin
                            w_load     = 1'b1;
                            n_out_kind = KIND_REG_ACK;
                            n_state    = S_IDLE;
                            if (!w_dly_ok) begin
                                n_out_st = ST_BAD_DELAY;
                            end else if (w_valid[DEPTH-1]) begin
                                n_out_st = ST_FULL;
                            end else begin
                                w_ctl.op = OP_INSERT;
                            end
                        end
                    end
                    CMD_ADJUST: begin
                        if (w_out_free) begin
                            n_out_kind = KIND_ADJ_ACK;
                            if (!w_seen[DEPTH]) begin
                                w_load   = 1'b1;
                                n_out_st = ST_NOT_FOUND;
                                n_state  = S_IDLE;
                            end else begin
                                w_ctl.op = OP_REMOVE;
                                if (w_dly_ok) begin
                                    n_state = S_REINS;
                                end else begin
                                    w_load   = 1'b1;
                                    n_out_st = ST_BAD_DELAY;
                                    n_state  = S_IDLE;
                                end
                            end
                        end
                    end
                    CMD_QUERY: begin
                        if (w_out_free) begin
                            w_load     = 1'b1;
                            n_out_kind = KIND_REMAIN;
                            n_state    = S_IDLE;
                            if (!w_seen[DEPTH]) begin
                                n_out_st = ST_NOT_FOUND;
                            end else if (!w_remain[31]) begin
                                n_out_tv = w_remain[30:0];
                            end
                        end
                    end
                    default: begin
                        if (r_now == r_last_tick) begin
                            n_state = S_IDLE;
                        end else begin
                            n_last_tick = r_now;
                            n_cnt       = '0;
                            n_state     = S_FIRE;
                        end
                    end
                endcase
            end
            S_REINS: begin
                if (w_out_free) begin
                    w_ctl      = '{op: OP_INSERT, key: r_id, start: r_adj_start,
                                   deadline: r_adj_dl};
                    w_load     = 1'b1;
                    n_out_kind = KIND_ADJ_ACK;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                // fire due timers from the head, one per cycle while the output is free
                if (!w_due[0]) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    w_ctl.op   = OP_POP;
                    w_load     = 1'b1;
                    n_out_kind = KIND_FIRED;
                    n_out_id   = w_entry[0].id;
                    n_out_tv   = w_elapsed[31] ? 31'd0 : w_elapsed[30:0];
                    n_out_last = !w_next_due;
                    n_cnt      = r_cnt + CNT_W'(1);
                    if (!w_next_due) begin
                        n_state = S_IDLE;
                    end
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_tick <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last_tick <= n_last_tick;
            r_cnt       <= n_cnt;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // capture the command word and the adjusted timer
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_s_axis_tuser;
            r_id  <= i_s_axis_tdata[7:0];
            r_dly <= i_s_axis_tdata[39:8];
            r_now <= i_s_axis_tdata[71:40];
        end
        if (r_state == S_EXEC) begin
            r_adj_start <= w_found_start;
            r_adj_dl    <= w_found_dl + r_dly;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_kind <= n_out_kind;
            r_out_id   <= n_out_id;
            r_out_tv   <= n_out_tv;
            r_out_st   <= n_out_st;
            r_out_last <= n_out_last;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_st, r_out_tv, r_out_id};
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTH
    // occupied cells always form a prefix of the row
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid + DEPTH'(1)) & w_valid) == '0)
        else $error("timer cells not contiguous");

    // a tick never fires more than the per-tick limit
    a_fire_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_FIRE))
        else $error("fire count over limit");

    // fired words always carry done status
    a_fired_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_FIRED) |-> (r_out_st == ST_DONE))
        else $error("fired word with nonzero status");

    // a cell row change happens only while a command is in progress
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> $stable(w_valid) || $past(r_state) != S_IDLE)
        else $error("timer row changed while idle");
`endif

endmodule

@@ tb/sdtq_checker.sv @@
module sdtq_checker
    import sdtq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [71:0] i_s_tdata,   // id[7:0], delay[39:8], now_ms[71:40]
    input  logic [1:0]  i_s_tuser,   // command[1:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,   // fired_id[7:0], time_value[38:8], status[40:39], zero
    input  logic [1:0]  i_m_tuser,   // kind[1:0]
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_words_checked,
    output int          o_fired_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  id;
        logic [30:0] time_value;
        logic [1:0]  status;
        logic        last;
    } t_result_word;

    // shadow of the timer table, kept sorted by deadline
    logic [7:0]   timer_key      [DEPTH];
    logic [31:0]  timer_start    [DEPTH];
    logic [31:0]  timer_deadline [DEPTH];
    int           timer_count;
    logic [31:0]  last_tick;

    t_result_word result_fifo[$];
    int           fail_count;
    int           words_checked;
    int           fired_count;

    initial begin
        fail_count    = 0;
        words_checked = 0;
        fired_count   = 0;
        timer_count   = 0;
        last_tick     = '0;
        o_fail_count    = 0;
        o_pending       = 0;
        o_words_checked = 0;
        o_fired_count   = 0;
    end

    task automatic queue_result(input logic [1:0] kind, input logic [7:0] id,
                                input logic [30:0] tv, input logic [1:0] status,
                                input logic last);
        t_result_word w;
        w.kind       = kind;
        w.id         = id;
        w.time_value = tv;
        w.status     = status;
        w.last       = last;
        result_fifo.push_back(w);
    endtask

    // insert after every timer whose deadline is not later
    task automatic insert_timer(input logic [7:0] id, input logic [31:0] start,
                                input logic [31:0] deadline);
        int pos;
        pos = 0;
        while (pos < timer_count && $signed(timer_deadline[pos]) <= $signed(deadline))
            pos++;
        for (int i = timer_count; i > pos; i--) begin
            timer_key[i]      = timer_key[i-1];
            timer_start[i]    = timer_start[i-1];
            timer_deadline[i] = timer_deadline[i-1];
        end
        timer_key[pos]      = id;
        timer_start[pos]    = start;
        timer_deadline[pos] = deadline;
        timer_count++;
    endtask

    // close the gap left by cnt timers starting at pos
    task automatic remove_timers(input int pos, input int cnt);
        for (int i = pos; i + cnt < timer_count; i++) begin
            timer_key[i]      = timer_key[i+cnt];
            timer_start[i]    = timer_start[i+cnt];
            timer_deadline[i] = timer_deadline[i+cnt];
        end
        timer_count -= cnt;
    endtask

    function automatic int find_timer(input logic [7:0] id);
        for (int i = 0; i < timer_count; i++)
            if (timer_key[i] == id)
                return i;
        return -1;
    endfunction

    // work out the result words of one accepted command word
    task automatic predict_command(input logic [1:0] cmd, input logic [7:0] id,
                                   input logic [31:0] dly, input logic [31:0] now);
        int          pos;
        int          due;
        logic [31:0] diff;
        logic [31:0] kept_start;
        logic [31:0] new_deadline;
        case (cmd)
            CMD_REGISTER: begin
                if ($signed(dly) <= 0) begin
                    queue_result(KIND_REG_ACK, id, '0, ST_BAD_DELAY, 1'b1);
                end else if (timer_count >= DEPTH) begin
                    queue_result(KIND_REG_ACK, id, '0, ST_FULL, 1'b1);
                end else begin
                    insert_timer(id, now, now + dly);
                    queue_result(KIND_REG_ACK, id, '0, ST_DONE, 1'b1);
                end
            end
            CMD_ADJUST: begin
                pos = find_timer(id);
                if (pos < 0) begin
                    queue_result(KIND_ADJ_ACK, id, '0, ST_NOT_FOUND, 1'b1);
                end else begin
                    kept_start   = timer_start[pos];
                    new_deadline = timer_deadline[pos] + dly;
                    remove_timers(pos, 1);
                    // a nonpositive extra delay cancels the timer
                    if ($signed(dly) <= 0) begin
                        queue_result(KIND_ADJ_ACK, id, '0, ST_BAD_DELAY, 1'b1);
                    end else begin
                        insert_timer(id, kept_start, new_deadline);
                        queue_result(KIND_ADJ_ACK, id, '0, ST_DONE, 1'b1);
                    end
                end
            end
            CMD_QUERY: begin
                pos = find_timer(id);
                if (pos < 0) begin
                    queue_result(KIND_REMAIN, id, '0, ST_NOT_FOUND, 1'b1);
                end else begin
                    diff = timer_deadline[pos] - now;
                    queue_result(KIND_REMAIN, id, diff[31] ? '0 : diff[30:0], ST_DONE, 1'b1);
                end
            end
            CMD_TICK: begin
                // a repeated tick time does nothing at all
                if (now != last_tick) begin
                    last_tick = now;
                    due = 0;
                    while (due < timer_count && due < MAX_FIRE &&
                           $signed(timer_deadline[due]) <= $signed(now))
                        due++;
                    for (int i = 0; i < due; i++) begin
                        diff = now - timer_start[i];
                        queue_result(KIND_FIRED, timer_key[i], diff[31] ? '0 : diff[30:0],
                                     ST_DONE, i == due - 1);
                    end
                    remove_timers(0, due);
                end
            end
            default: ;
        endcase
    endtask

    // compare one accepted result word with the oldest prediction
    task automatic check_word();
        t_result_word got;
        t_result_word want;
        got.kind       = i_m_tuser;
        got.id         = i_m_tdata[7:0];
        got.time_value = i_m_tdata[38:8];
        got.status     = i_m_tdata[40:39];
        got.last       = i_m_tlast;
        words_checked++;
        if (got.kind == KIND_FIRED)
            fired_count++;
        if (result_fifo.size() == 0) begin
            fail_count++;
            $display("%0t sdtq_checker: unexpected word kind=%0d id=%0d time=%0d %s%0d last=%0d",
                     $time, got.kind, got.id, got.time_value, "status=", got.status,
                     got.last);
        end else begin
            want = result_fifo.pop_front();
            if (got !== want || i_m_tdata[47:41] !== '0) begin
                fail_count++;
                $display("%0t sdtq_checker: mismatch expected kind=%0d id=%0d time=%0d %s%0d %s%0d",
                         $time, want.kind, want.id, want.time_value, "status=", want.status,
                         "last=", want.last);
                $display("%0t sdtq_checker: actual kind=%0d id=%0d time=%0d %s%0d %s%0d pad=%0h",
                         $time, got.kind, got.id, got.time_value, "status=", got.status,
                         "last=", got.last, i_m_tdata[47:41]);
            end
        end
    endtask

    // watch both channels at every edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            timer_count = 0;
            last_tick   = '0;
            result_fifo.delete();
        end else begin
            if (i_m_tvalid && i_m_tready)
                check_word();
            if (i_s_tvalid && i_s_tready)
                predict_command(i_s_tuser, i_s_tdata[7:0], i_s_tdata[39:8], i_s_tdata[71:40]);
        end
        o_fail_count    = fail_count;
        o_pending       = result_fifo.size();
        o_words_checked = words_checked;
        o_fired_count   = fired_count;
    end

endmodule

@@ tb/tb.sv @@
module tb
    import sdtq_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS   = 192;
    localparam int CALM_WORDS     = 40;
    // ids that random commands come back to, so adjust and query find timers
    localparam logic [63:0] ID_POOL = 64'hff_fe_c3_80_7f_3c_01_00;
    localparam logic [31:0] T0 = 32'd1000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;    // id[7:0], delay[39:8], now_ms[71:40]
    logic [1:0]  s_tuser = '0;    // command[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // fired_id[7:0], time_value[38:8], status[40:39], zero
    logic [1:0]  m_tuser;         // kind[1:0]
    logic        m_tlast;

    int          fail_count;
    int          pending;
    int          words_checked;
    int          fired_count;
    int          sent_count = 0;
    int          sink_hold = 0;
    int          quiet_cycles = 0;
    bit          allow_idle = 1'b1;
    logic [31:0] last_tick_sent = '0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    sorted_deadline_timer_queue u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    sdtq_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_s_tuser       (s_tuser),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tuser       (m_tuser),
        .i_m_tlast       (m_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_words_checked (words_checked),
        .o_fired_count   (fired_count)
    );

    // stall the result side in random bursts
    always @(posedge clk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_tready  <= (sink_hold == 1);
        end else if (allow_idle && $urandom_range(0, 7) == 0) begin
            sink_hold <= $urandom_range(1, 6);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // end the run when nothing moves for too long
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb: watchdog expired at %0t with %0d words outstanding", $time, pending);
            $display("tb: FAIL");
            $finish;
        end
    end

    // present one command word and hold it until accepted
    task automatic send_command(input logic [1:0] cmd, input logic [7:0] id,
                                input logic [31:0] dly, input logic [31:0] now);
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {now, dly, id};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent_count++;
        if (cmd == CMD_TICK)
            last_tick_sent = now;
    endtask

    function automatic logic [7:0] pick_id();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, 255));
        return ID_POOL[8*$urandom_range(0, 7) +: 8];
    endfunction

    initial begin
        logic [31:0] cur_time;
        logic [31:0] dly;
        int          pick;
        bit          fill_phase;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset tick time, bad delays, absent ids
        send_command(CMD_TICK, 8'h00, 32'd0, 32'd0);
        send_command(CMD_REGISTER, 8'h00, 32'd0, T0);
        send_command(CMD_REGISTER, 8'hff, 32'h8000_0000, T0);
        send_command(CMD_QUERY, 8'h5a, 32'd0, T0);
        send_command(CMD_ADJUST, 8'h5a, 32'd5, T0);
        // fill the table with tied deadlines; the last one wraps negative
        for (int i = 0; i < 16; i++)
            send_command(CMD_REGISTER, 8'(i * 17),
                         (i == 15) ? 32'h7fff_ffff : 32'(5 + (i % 4) * 10), T0);
        send_command(CMD_REGISTER, 8'h99, 32'd1, T0);
        // past deadline clamps, cancel by nonpositive adjust
        send_command(CMD_QUERY, 8'd17, 32'd0, T0 + 32'd100);
        send_command(CMD_ADJUST, 8'd0, 32'hffff_fffb, T0);
        // fire part, then the rest
        send_command(CMD_TICK, 8'h00, 32'd0, T0 + 32'd15);
        send_command(CMD_TICK, 8'h00, 32'd0, T0 + 32'd1000);
        // deadline wraps below a tick whose time reads before the start
        send_command(CMD_REGISTER, 8'h42, 32'h0000_0020, 32'h7fff_fff0);
        send_command(CMD_TICK, 8'h00, 32'd0, 32'd0);

        // random: alternate filling and draining phases
        cur_time = 32'd5000;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 25 == 0)
                allow_idle = (n < RANDOM_WORDS - CALM_WORDS) && ($urandom_range(0, 3) != 0);
            if (n >= RANDOM_WORDS - CALM_WORDS)
                allow_idle = 1'b0;
            fill_phase = ((n / 30) % 2) == 0;
            if (n % 60 == 59)
                cur_time = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                // noise: every field fully random
                send_command(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                             $urandom, $urandom);
            end else if (pick < (fill_phase ? 65 : 35)) begin
                pick = $urandom_range(0, 99);
                if (pick < 85)
                    dly = $urandom_range(1, 60);
                else if (pick < 93)
                    dly = (pick % 2) ? 32'd0 : 32'd0 - $urandom_range(1, 100);
                else
                    dly = $urandom & 32'h7fff_ffff;
                send_command(CMD_REGISTER, pick_id(), dly, cur_time);
            end else if (pick < (fill_phase ? 78 : 50)) begin
                if ($urandom_range(0, 3) == 0)
                    dly = 32'd0 - $urandom_range(0, 50);
                else
                    dly = $urandom_range(1, 40);
                send_command(CMD_ADJUST, pick_id(), dly, cur_time);
            end else if (pick < (fill_phase ? 90 : 65)) begin
                send_command(CMD_QUERY, pick_id(), $urandom,
                             cur_time + $urandom_range(0, 40));
            end else if ($urandom_range(0, 6) == 0) begin
                send_command(CMD_TICK, pick_id(), $urandom, last_tick_sent);
            end else begin
                cur_time = cur_time + $urandom_range(0, 25);
                send_command(CMD_TICK, pick_id(), $urandom, cur_time);
            end
        end
        s_tvalid <= 1'b0;

        // drain, then let the block settle
        do @(posedge clk); while (pending != 0);
        repeat (20) @(posedge clk);

        $display("tb: %0d command words sent, %0d result words checked, %0d timers fired",
                 sent_count, words_checked, fired_count);
        $display("tb: covered full table, tied and wrapped deadlines, cancels and repeated ticks");
        if (pending != 0)
            $display("tb: %0d expected words never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/sdtq_pkg.sv
sv/sdtq_cell.sv
sv/sorted_deadline_timer_queue.sv
tb/sdtq_checker.sv
tb/tb.sv
